// ===== rtl/xbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the character classifier for the XBM text decoder.
// No dependencies; every other file refers to this package by scoped names.
package xbm_pkg;

    // Size limits and field widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;   // config width/height fields
    localparam int POS_W      = 13;   // internal row/col, can hold the limit itself
    localparam int OUT_POS_W  = 12;   // row/col as seen on the pixel word
    localparam int WORD_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int BITCNT_W   = 5;    // counts 0..WORD_W
    localparam int REG_IDX_W  = 2;

    localparam logic [BITCNT_W-1:0] BITS_SHORT = BITCNT_W'(16);
    localparam logic [BITCNT_W-1:0] BITS_CHAR  = BITCNT_W'(8);

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FORMAT = 2'd2
    } reg_idx_t;

    // Emitter states
    typedef enum logic {
        EM_IDLE,
        EM_RUN
    } em_state_t;

    // Character kinds
    typedef enum logic [1:0] {
        CK_DIGIT,
        CK_SEP,
        CK_END
    } char_kind_t;

    typedef struct packed {
        char_kind_t             kind;
        logic [DIGIT_W-1:0]     digit;
    } char_class_t;

    // Clamped configuration as used by the datapath
    typedef struct packed {
        logic [POS_W-1:0] eff_w;
        logic [POS_W-1:0] eff_h;
        logic             len8;
    } dims_t;

    // Tokenizer to emitter
    typedef struct packed {
        logic               accept;
        logic               start;
        logic [WORD_W-1:0]  word;
    } tok_req_t;

    // Emitter to tokenizer and top
    typedef struct packed {
        logic busy;
        logic done;
    } em_status_t;

    // Classify one text character; unlisted characters count as digit zero
    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r.kind  = CK_DIGIT;
        r.digit = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.digit = DIGIT_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.digit = DIGIT_W'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.digit = DIGIT_W'(c - 8'h37);
        end else if (c == 8'h2C || c == 8'h0A) begin
            r.kind = CK_END;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h7D || c == 8'h00) begin
            r.kind = CK_SEP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/xbm_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: text characters, pixel words, config writes.
// Depends on xbm_pkg for field widths.
interface xbm_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    modport source (output valid, output text_char, input ready);
    modport sink   (input valid, input text_char, output ready);
endinterface

interface xbm_pix_if;
    logic                          valid;
    logic                          ready;
    logic [xbm_pkg::OUT_POS_W-1:0] pixel_row;
    logic [xbm_pkg::OUT_POS_W-1:0] pixel_col;
    logic                          pixel_black;
    logic                          run_last;
    logic                          image_done;
    modport source (output valid, output pixel_row, output pixel_col, output pixel_black,
                    output run_last, output image_done, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, input pixel_black,
                    input run_last, input image_done, output ready);
endinterface

interface xbm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [xbm_pkg::REG_IDX_W-1:0] reg_index;
    logic [xbm_pkg::DIM_W-1:0]     wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/xbm_hex_text_to_pixels.sv =====
`timescale 1ns / 1ps
// XBM bits-array text to pixel stream. A character that does not close a token is absorbed
// without lowering text.ready. A closing comma/newline with a taken token keeps text.ready
// low while the emitter runs: n pixels (at most 16), one per cycle unless the receiver stalls,
// from the emitter shift register, then a closing step that also advances the row when it is
// full. The first pixel word reaches the output register after the emitter enters its run
// state. Reset clears all token and position state and sets width 8, height 8, 16-bit words.
module xbm_hex_text_to_pixels (
    input  logic       clk,
    input  logic       rst_n,
    xbm_char_if.sink   text,
    xbm_pix_if.source  pixels,
    xbm_cfg_if.sink    cfg
);

    logic [xbm_pkg::DIM_W-1:0] width_reg;
    logic [xbm_pkg::DIM_W-1:0] height_reg;
    logic                      format_reg;
    xbm_pkg::dims_t            dims;
    xbm_pkg::tok_req_t         req;
    xbm_pkg::em_status_t       status;
    logic                      text_accept;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= xbm_pkg::DIM_W'(8);
            height_reg <= xbm_pkg::DIM_W'(8);
            format_reg <= 1'b0;
        end else if (cfg.valid) begin
            unique case (cfg.reg_index)
                xbm_pkg::REG_WIDTH:  width_reg  <= cfg.wdata;
                xbm_pkg::REG_HEIGHT: height_reg <= cfg.wdata;
                xbm_pkg::REG_FORMAT: format_reg <= cfg.wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Clamp to the supported image size
    always_comb begin
        dims.eff_w = (width_reg > xbm_pkg::DIM_W'(xbm_pkg::MAX_WIDTH))
                     ? xbm_pkg::POS_W'(xbm_pkg::MAX_WIDTH) : xbm_pkg::POS_W'(width_reg);
        dims.eff_h = (height_reg > xbm_pkg::DIM_W'(xbm_pkg::MAX_HEIGHT))
                     ? xbm_pkg::POS_W'(xbm_pkg::MAX_HEIGHT) : xbm_pkg::POS_W'(height_reg);
        dims.len8  = format_reg;
    end

    assign text.ready  = !status.busy;
    assign text_accept = text.valid && !status.busy;

    xbm_token u_token (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (text_accept),
        .text_char (text.text_char),
        .status    (status),
        .req       (req)
    );

    xbm_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .dims   (dims),
        .req    (req),
        .status (status),
        .pixels (pixels)
    );

endmodule

// ===== rtl/xbm_token.sv =====
`timescale 1ns / 1ps
// Tokenizer: classifies characters and shifts hex digits into the token word.
// Depends on xbm_pkg.
module xbm_token (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            text_char,
    input  xbm_pkg::em_status_t   status,
    output xbm_pkg::tok_req_t     req
);

    logic [xbm_pkg::WORD_W-1:0] word_reg, word_next;
    logic                       seen_reg, seen_next;
    logic                       taken_reg, taken_next;
    logic                       skip_reg, skip_next;
    xbm_pkg::char_class_t       cls;

    // Token state update
    always_comb begin
        cls        = xbm_pkg::classify(text_char);
        word_next  = word_reg;
        seen_next  = seen_reg;
        taken_next = taken_reg;
        skip_next  = skip_reg;
        req.accept = accept;
        req.start  = 1'b0;
        req.word   = word_reg;
        if (accept && !status.done) begin
            if (cls.kind == xbm_pkg::CK_END) begin
                req.start  = taken_reg;
                word_next  = '0;
                seen_next  = 1'b0;
                taken_next = 1'b0;
                skip_next  = 1'b0;
            end else if (!skip_reg) begin
                if (cls.kind == xbm_pkg::CK_DIGIT) begin
                    word_next  = {word_reg[xbm_pkg::WORD_W-xbm_pkg::DIGIT_W-1:0], cls.digit};
                    seen_next  = 1'b1;
                    taken_next = 1'b1;
                end else if (seen_reg) begin
                    // separator after digits closes the digit run
                    taken_next = 1'b1;
                    skip_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            word_reg  <= '0;
            seen_reg  <= 1'b0;
            taken_reg <= 1'b0;
            skip_reg  <= 1'b0;
        end else begin
            word_reg  <= word_next;
            seen_reg  <= seen_next;
            taken_reg <= taken_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ===== rtl/xbm_emit.sv =====
`timescale 1ns / 1ps
// Pixel emitter: shifts the token word out one bit per cycle into the output register,
// stalling while that register is held, and tracks row/column. Depends on xbm_pkg and xbm_ifs.
module xbm_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  xbm_pkg::dims_t      dims,
    input  xbm_pkg::tok_req_t   req,
    output xbm_pkg::em_status_t status,
    xbm_pix_if.source           pixels
);

    xbm_pkg::em_state_t            state_reg, state_next;
    logic [xbm_pkg::WORD_W-1:0]    shift_reg, shift_next;
    logic [xbm_pkg::BITCNT_W-1:0]  bitcnt_reg, bitcnt_next;
    logic                          len8_reg, len8_next;
    logic [xbm_pkg::POS_W-1:0]     row_reg, row_next;
    logic [xbm_pkg::POS_W-1:0]     col_reg, col_next;
    logic                          done_reg, done_next;

    logic                          out_valid_reg, out_valid_next;
    logic [xbm_pkg::OUT_POS_W-1:0] out_row_reg, out_row_next;
    logic [xbm_pkg::OUT_POS_W-1:0] out_col_reg, out_col_next;
    logic                          out_black_reg, out_black_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_done_reg, out_done_next;

    logic [xbm_pkg::BITCNT_W-1:0]  bits_total;
    logic [xbm_pkg::POS_W-1:0]     col_p1, row_p1;
    logic                          slot_free, row_full, col_end;

    assign status.busy = (state_reg == xbm_pkg::EM_RUN);
    assign status.done = done_reg || (row_reg >= dims.eff_h);

    // Next state, one pixel per cycle while the output slot is free
    always_comb begin
        bits_total     = len8_reg ? xbm_pkg::BITS_CHAR : xbm_pkg::BITS_SHORT;
        col_p1         = col_reg + xbm_pkg::POS_W'(1);
        row_p1         = row_reg + xbm_pkg::POS_W'(1);
        slot_free      = !out_valid_reg || pixels.ready;
        row_full       = (col_reg >= dims.eff_w);
        col_end        = (col_p1 >= dims.eff_w);

        state_next     = state_reg;
        shift_next     = shift_reg;
        bitcnt_next    = bitcnt_reg;
        len8_next      = len8_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !pixels.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_black_next = out_black_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        unique case (state_reg)
            xbm_pkg::EM_IDLE: begin
                // sticky completion once a character sees the last row passed
                if (req.accept && row_reg >= dims.eff_h) begin
                    done_next = 1'b1;
                end
                if (req.start) begin
                    shift_next  = req.word;
                    bitcnt_next = '0;
                    len8_next   = dims.len8;
                    state_next  = xbm_pkg::EM_RUN;
                end
            end
            xbm_pkg::EM_RUN: begin
                if (!row_full && bitcnt_reg != bits_total) begin
                    if (slot_free) begin
                        out_valid_next = 1'b1;
                        out_row_next   = row_reg[xbm_pkg::OUT_POS_W-1:0];
                        out_col_next   = col_reg[xbm_pkg::OUT_POS_W-1:0];
                        out_black_next = shift_reg[0];
                        out_last_next  = col_end
                                         || (bitcnt_reg == bits_total - xbm_pkg::BITCNT_W'(1));
                        out_done_next  = col_end && (row_p1 >= dims.eff_h);
                        shift_next     = {1'b0, shift_reg[xbm_pkg::WORD_W-1:1]};
                        bitcnt_next    = bitcnt_reg + xbm_pkg::BITCNT_W'(1);
                        col_next       = col_p1;
                    end
                end else begin
                    // token finished: advance the row if it is full
                    if (row_full) begin
                        col_next = '0;
                        row_next = row_p1;
                        if (row_p1 >= dims.eff_h) begin
                            done_next = 1'b1;
                        end
                    end
                    state_next = xbm_pkg::EM_IDLE;
                end
            end
            default: state_next = xbm_pkg::EM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= xbm_pkg::EM_IDLE;
            bitcnt_reg    <= '0;
            len8_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bitcnt_reg    <= bitcnt_next;
            len8_reg      <= len8_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        shift_reg     <= shift_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_black_reg <= out_black_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_row   = out_row_reg;
    assign pixels.pixel_col   = out_col_reg;
    assign pixels.pixel_black = out_black_reg;
    assign pixels.run_last    = out_last_reg;
    assign pixels.image_done  = out_done_reg;

endmodule

// ===== sim/xbm_hex_text_to_pixels_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for xbm_hex_text_to_pixels: text characters in, pixel words out.
// Depends on xbm_pkg and the channel interfaces in xbm_ifs.sv; the block is checked
// word by word against a behavioral decoder kept in this file.
module xbm_hex_text_to_pixels_test;

    // Character codes used by the decoder and the stimulus
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_X_LO    = 8'h78;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam int SETTLE_CYCLES = 24;       // row update plus a full 16-pixel burst
    localparam int HOLD_CYCLES   = 300;
    localparam int CLAMP_TOKENS  = 16;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    // One pixel word as seen on the output channel
    typedef struct packed {
        logic [xbm_pkg::OUT_POS_W-1:0] row;
        logic [xbm_pkg::OUT_POS_W-1:0] col;
        logic                          black;
        logic                          last;
        logic                          done;
    } pix_t;

    // Directed row: a character, and for token ends the pixels read off by hand
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic [4:0]  npix;
        logic [11:0] row;
        logic [15:0] bits;
    } dir_row_t;

    // Default config: 8 wide, 8 high, 16-bit words, so each taken token fills one row
    localparam dir_row_t DIRECTED [27] = '{
        '{"0",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"x",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"a",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"5",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_COMMA,  1'b1, 5'd8, 12'd0, 16'h00A5},
        '{"F",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"F",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"F",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"F",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_NL,     1'b1, 5'd8, 12'd1, 16'hFFFF},
        '{CH_COMMA,  1'b1, 5'd0, 12'd0, 16'h0000},   // empty token
        '{CH_SPACE,  1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_COMMA,  1'b1, 5'd0, 12'd0, 16'h0000},   // only a separator
        '{"1",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"2",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"3",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"4",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{"5",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_COMMA,  1'b1, 5'd8, 12'd2, 16'h2345},   // fifth digit overflows
        '{"7",       1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_RBRACE, 1'b0, 5'd0, 12'd0, 16'h0000},
        '{"9",       1'b0, 5'd0, 12'd0, 16'h0000},   // dropped after the brace
        '{CH_COMMA,  1'b1, 5'd8, 12'd3, 16'h0007},
        '{CH_TAB,    1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_NUL,    1'b0, 5'd0, 12'd0, 16'h0000},
        '{CH_X_UP,   1'b0, 5'd0, 12'd0, 16'h0000},   // counts as digit zero
        '{CH_COMMA,  1'b1, 5'd8, 12'd4, 16'h0000}
    };

    logic clk;
    logic rst_n;

    xbm_char_if text_ch ();
    xbm_pix_if  pix_ch ();
    xbm_cfg_if  cfg_ch ();

    xbm_hex_text_to_pixels uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .pixels (pix_ch),
        .cfg    (cfg_ch)
    );

    // Decoder state mirrored by the bench
    logic [xbm_pkg::DIM_W-1:0] cfg_width;
    logic [xbm_pkg::DIM_W-1:0] cfg_height;
    logic                      cfg_char8;
    logic [15:0]               tok_word;
    bit                        tok_digits;
    bit                        tok_taken;
    bit                        tok_skip;
    int unsigned               pos_row;
    int unsigned               pos_col;
    bit                        img_done;

    pix_t burst [16];
    pix_t pixels_due [$];
    int   mismatches;
    bit   calm;
    bit   hold_req;

    // Hex digit value, -1 for a separator; anything unlisted is a zero digit
    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        if (c == CH_SPACE || c == CH_TAB || c == CH_RBRACE || c == CH_NUL) return -1;
        return 0;
    endfunction

    // Advance the decoder by one character; pixels land in burst, count returned
    function automatic int decode_char(input logic [7:0] c);
        int unsigned w;
        int unsigned h;
        int unsigned nbits;
        int unsigned b;
        int n;
        int d;
        w = (cfg_width > xbm_pkg::MAX_WIDTH) ? xbm_pkg::MAX_WIDTH : cfg_width;
        h = (cfg_height > xbm_pkg::MAX_HEIGHT) ? xbm_pkg::MAX_HEIGHT : cfg_height;
        n = 0;
        if (pos_row >= h) img_done = 1'b1;
        if (img_done) return 0;
        if (c == CH_COMMA || c == CH_NL) begin
            if (tok_taken) begin
                nbits = cfg_char8 ? 8 : 16;
                b = 0;
                while (pos_col < w && b < nbits) begin
                    burst[n] = '{row: pos_row[11:0], col: pos_col[11:0],
                                 black: tok_word[b], last: 1'b0, done: 1'b0};
                    pos_col++;
                    b++;
                    n++;
                end
                if (n > 0) burst[n-1].last = 1'b1;
                if (pos_col >= w) begin
                    pos_col = 0;
                    pos_row++;
                    if (pos_row >= h) begin
                        img_done = 1'b1;
                        if (n > 0) burst[n-1].done = 1'b1;
                    end
                end
            end
            tok_word   = '0;
            tok_digits = 1'b0;
            tok_taken  = 1'b0;
            tok_skip   = 1'b0;
            return n;
        end
        if (tok_skip) return 0;
        d = hex_value(c);
        if (d >= 0) begin
            tok_word   = {tok_word[11:0], 4'(d)};
            tok_digits = 1'b1;
            tok_taken  = 1'b1;
        end else if (tok_digits) begin
            tok_taken = 1'b1;
            tok_skip  = 1'b1;
        end
        return 0;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        if ($urandom_range(0, 1) == 1) return CH_UPPER_A + 8'(v - 4'd10);
        return CH_LOWER_A + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_RBRACE;
            default: return CH_NUL;
        endcase
    endfunction

    // Offer one character and return at the edge where it is taken
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_char <= c;
        do @(posedge clk); while (!text_ch.ready);
    endtask

    task automatic feed_char(input logic [7:0] c);
        int n;
        send_char(c);
        n = decode_char(c);
        for (int k = 0; k < n; k++) pixels_due.push_back(burst[k]);
    endtask

    // Stop offering text and wait for every pixel still owed
    task automatic drain();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0) @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input xbm_pkg::reg_idx_t idx,
                             input logic [xbm_pkg::DIM_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            xbm_pkg::REG_WIDTH:  cfg_width  = val;
            xbm_pkg::REG_HEIGHT: cfg_height = val;
            xbm_pkg::REG_FORMAT: cfg_char8  = val[0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random token: mostly well formed, some noise, empty and cut-short ones
    task automatic send_token(output int sent);
        logic [7:0] txt [$];
        int kind;
        int nd;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            if ($urandom_range(0, 1) == 1) txt.push_back(sep_char());
            txt.push_back(CH_COMMA);
        end else begin
            if ($urandom_range(0, 2) == 0) txt.push_back(sep_char());
            if ($urandom_range(0, 1) == 1) begin
                txt.push_back(CH_ZERO);
                txt.push_back(($urandom_range(0, 1) == 1) ? CH_X_UP : CH_X_LO);
            end
            nd = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            repeat (nd) txt.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 4) == 0) begin
                txt.push_back(sep_char());
                txt.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            txt.push_back(($urandom_range(0, 3) == 0) ? CH_NL : CH_COMMA);
        end
        foreach (txt[i]) feed_char(txt[i]);
        sent = txt.size();
    endtask

    task automatic random_text(input int n_items, input bit mid_drain);
        int count;
        int sent;
        bit drained;
        count   = 0;
        drained = 1'b0;
        while (count < n_items) begin
            send_token(sent);
            count += sent;
            if (mid_drain && !drained && count >= n_items / 2) begin
                drain();
                drained = 1'b1;
            end
        end
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("** xbm_hex_text_to_pixels: FAILED **");
        $finish;
    end

    // Pixel receiver: random stalls, plus one long hold on request
    initial begin
        int stall;
        stall        = 0;
        pix_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pix_ch.ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                pix_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall = pick_gap() - 1;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each taken pixel word with the oldest one owed
    always @(posedge clk) begin
        pix_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready) begin
            if (pixels_due.size() == 0) begin
                $error("unexpected pixel word: row %0d col %0d", pix_ch.pixel_row,
                       pix_ch.pixel_col);
                mismatches++;
            end else begin
                want = pixels_due.pop_front();
                if (pix_ch.pixel_row !== want.row) begin
                    $error("pixel_row: expected %0d, got %0d", want.row, pix_ch.pixel_row);
                    mismatches++;
                end
                if (pix_ch.pixel_col !== want.col) begin
                    $error("pixel_col: expected %0d, got %0d", want.col, pix_ch.pixel_col);
                    mismatches++;
                end
                if (pix_ch.pixel_black !== want.black) begin
                    $error("pixel_black: expected %0d, got %0d", want.black,
                           pix_ch.pixel_black);
                    mismatches++;
                end
                if (pix_ch.run_last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, pix_ch.run_last);
                    mismatches++;
                end
                if (pix_ch.image_done !== want.done) begin
                    $error("image_done: expected %0d, got %0d", want.done,
                           pix_ch.image_done);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int n;
        int sent;
        int guard;
        rst_n             = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_char = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = xbm_pkg::REG_WIDTH;
        cfg_ch.wdata      = '0;
        mismatches        = 0;
        calm              = 1'b0;
        hold_req          = 1'b0;
        cfg_width         = 13'd8;
        cfg_height        = 13'd8;
        cfg_char8         = 1'b0;
        tok_word          = '0;
        tok_digits        = 1'b0;
        tok_taken         = 1'b0;
        tok_skip          = 1'b0;
        pos_row           = 0;
        pos_col           = 0;
        img_done          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tokens at reset config
        foreach (DIRECTED[i]) begin
            send_char(DIRECTED[i].ch);
            n = decode_char(DIRECTED[i].ch);
            if (DIRECTED[i].typed) begin
                for (int k = 0; k < DIRECTED[i].npix; k++)
                    pixels_due.push_back('{row: DIRECTED[i].row, col: 12'(k),
                                           black: DIRECTED[i].bits[k],
                                           last: (k == DIRECTED[i].npix - 1), done: 1'b0});
            end else begin
                for (int k = 0; k < n; k++) pixels_due.push_back(burst[k]);
            end
        end
        settle();

        // Oversize width and height clamp to the limit; run well past the old row end
        write_reg(xbm_pkg::REG_HEIGHT, 13'h1FFF);
        write_reg(xbm_pkg::REG_WIDTH, 13'h1FFF);
        write_reg(xbm_pkg::REG_FORMAT, 13'd0);
        calm = 1'b1;
        repeat (CLAMP_TOKENS) begin
            feed_char(hex_char(4'($urandom_range(0, 15))));
            feed_char(CH_COMMA);
        end
        calm = 1'b0;
        settle();

        // One pixel per row, byte words
        write_reg(xbm_pkg::REG_WIDTH, 13'd1);
        write_reg(xbm_pkg::REG_FORMAT, 13'd1);
        random_text(30, 1'b0);
        settle();

        // Zero width: taken tokens only move the row
        write_reg(xbm_pkg::REG_WIDTH, 13'd0);
        write_reg(xbm_pkg::REG_FORMAT, 13'd0);
        random_text(20, 1'b0);
        settle();

        // Long receiver hold while text keeps coming
        write_reg(xbm_pkg::REG_WIDTH, 13'd37);
        hold_req = 1'b1;
        random_text(40, 1'b0);
        settle();

        // Width lowered below the current column
        write_reg(xbm_pkg::REG_WIDTH, 13'd100);
        repeat (3) begin
            feed_char("5");
            feed_char(CH_COMMA);
        end
        settle();
        write_reg(xbm_pkg::REG_WIDTH, 13'd20);
        random_text(40, 1'b1);
        settle();

        // Full-size width, byte words, no idling
        write_reg(xbm_pkg::REG_WIDTH, 13'd4096);
        write_reg(xbm_pkg::REG_FORMAT, 13'd1);
        calm = 1'b1;
        random_text(40, 1'b0);
        calm = 1'b0;
        settle();

        // Finish the image two rows on, then everything is ignored
        write_reg(xbm_pkg::REG_WIDTH, 13'd3);
        write_reg(xbm_pkg::REG_HEIGHT, 13'(pos_row + 2));
        while (!img_done) send_token(sent);
        repeat (20) feed_char(8'($urandom_range(0, 255)));
        settle();
        write_reg(xbm_pkg::REG_HEIGHT, 13'd0);
        repeat (10) feed_char(8'($urandom_range(0, 255)));

        // Wait out the last pixels, bounded
        text_ch.valid <= 1'b0;
        guard = 0;
        while (pixels_due.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pixels_due.size() != 0) begin
            $error("%0d pixel words never arrived", pixels_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** xbm_hex_text_to_pixels: PASSED **");
        else
            $display("** xbm_hex_text_to_pixels: FAILED **");
        $finish;
    end

endmodule

// ===== xbm_hex_text_to_pixels.f =====
rtl/xbm_pkg.sv
rtl/xbm_ifs.sv
rtl/xbm_token.sv
rtl/xbm_emit.sv
rtl/xbm_hex_text_to_pixels.sv
sim/xbm_hex_text_to_pixels_test.sv
